[rtl/core/modexp_pkg.sv]
package modexp_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
  localparam int S_TDATA_W = ((3 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((OPERAND_WIDTH + 7) / 8) * 8;

  localparam logic [OPERAND_WIDTH-1:0] OPND_ZERO = '0;
  localparam logic [OPERAND_WIDTH-1:0] OPND_ONE = OPERAND_WIDTH'(1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

  localparam int SEL_W = 2;
  localparam logic [SEL_W-1:0] SEL_REDUCE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_MUL_R = 2'd1;
  localparam logic [SEL_W-1:0] SEL_SQUARE = 2'd2;

  typedef struct packed {
    logic             load;
    logic             start;
    logic [SEL_W-1:0] sel;
    logic             step;
    logic             wr_r;
    logic             wr_b;
    logic             next_bit;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic e_lsb;
    logic mul_last;
    logic bits_done;
  } dp_stat_t;

endpackage

[rtl/core/modular_exponentiation.sv]
// per request: the base is reduced, then for each of the W exponent bits, LSB first, the result is
// multiplied by the base if the bit is set and the base is squared; a zero modulus goes straight to the result
// one request at a time; the shift-and-subtract modular multiplier works one bit per cycle
// a new request is taken once the previous one has moved into the output register
// reset is asynchronous active low and clears the controller state and output valid
module modular_exponentiation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // base, exponent, modulus
  input  logic [modexp_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // power_mod
  output logic [modexp_pkg::M_TDATA_W-1:0] m_tdata,
  // bad_modulus
  output logic                             m_tuser
);

  localparam int W = modexp_pkg::OPERAND_WIDTH;

  modexp_pkg::dp_cmd_t  cmd;
  modexp_pkg::dp_stat_t stat;
  logic [W-1:0]         power_mod;

  modexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  modexp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .base_i        (s_tdata[W-1:0]),
    .exponent_i    (s_tdata[2*W-1:W]),
    .modulus_i     (s_tdata[3*W-1:2*W]),
    .power_mod_o   (power_mod),
    .bad_modulus_o (m_tuser)
  );

  assign m_tdata = modexp_pkg::M_TDATA_W'(power_mod);

endmodule

[rtl/core/modexp_dp.sv]
module modexp_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  modexp_pkg::dp_cmd_t                  cmd_i,
  output modexp_pkg::dp_stat_t                 stat_o,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] base_i,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] exponent_i,
  input  logic [modexp_pkg::OPERAND_WIDTH-1:0] modulus_i,
  output logic [modexp_pkg::OPERAND_WIDTH-1:0] power_mod_o,
  output logic                                 bad_modulus_o
);

  localparam int W = modexp_pkg::OPERAND_WIDTH;

  logic [W-1:0] b_q, e_q, m_q, r_q;
  logic [W-1:0] acc_q, acc_d, x_q, y_q;
  logic [modexp_pkg::CNT_W-1:0] mcnt_q, bcnt_q;
  logic [W-1:0] pm_q;
  logic         bad_q;

  logic [W:0]   dbl, mw, d1, s, d2;
  logic [W-1:0] addend;

  // one double-and-add step of the interleaved modular multiply
  always_comb begin
    mw     = {1'b0, m_q};
    dbl    = {acc_q, 1'b0};
    d1     = (dbl >= mw) ? (dbl - mw) : dbl;
    addend = x_q[W-1] ? y_q : modexp_pkg::OPND_ZERO;
    s      = {1'b0, d1[W-1:0]} + {1'b0, addend};
    d2     = (s >= mw) ? (s - mw) : s;
    acc_d  = d2[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      bcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        bcnt_q <= modexp_pkg::CNT_LAST;
      end else if (cmd_i.next_bit) begin
        bcnt_q <= bcnt_q - 1'b1;
      end
      if (cmd_i.start) begin
        mcnt_q <= modexp_pkg::CNT_LAST;
      end else if (cmd_i.step) begin
        mcnt_q <= mcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q <= base_i;
      e_q <= exponent_i;
      m_q <= modulus_i;
      r_q <= (modulus_i == modexp_pkg::OPND_ONE) ? modexp_pkg::OPND_ZERO
                                                 : modexp_pkg::OPND_ONE;
    end else begin
      if (cmd_i.wr_r) begin
        r_q <= acc_q;
      end
      if (cmd_i.wr_b) begin
        b_q <= acc_q;
      end
      if (cmd_i.next_bit) begin
        e_q <= e_q >> 1;
      end
    end

    if (cmd_i.start) begin
      acc_q <= modexp_pkg::OPND_ZERO;
      case (cmd_i.sel)
        modexp_pkg::SEL_REDUCE: begin
          x_q <= b_q;
          y_q <= r_q;
        end
        modexp_pkg::SEL_MUL_R: begin
          x_q <= r_q;
          y_q <= b_q;
        end
        default: begin
          x_q <= b_q;
          y_q <= b_q;
        end
      endcase
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      x_q   <= x_q << 1;
    end

    if (cmd_i.out_load) begin
      pm_q  <= (m_q == modexp_pkg::OPND_ZERO) ? modexp_pkg::OPND_ZERO : r_q;
      bad_q <= (m_q == modexp_pkg::OPND_ZERO);
    end
  end

  assign stat_o.m_zero    = (m_q == modexp_pkg::OPND_ZERO);
  assign stat_o.e_lsb     = e_q[0];
  assign stat_o.mul_last  = (mcnt_q == '0);
  assign stat_o.bits_done = (bcnt_q == '0);

  assign power_mod_o   = pm_q;
  assign bad_modulus_o = bad_q;

`ifndef ASSERT_OFF
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> (acc_q == modexp_pkg::OPND_ZERO))
    else $error("accumulator not cleared at multiply start");

  a_r_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_r && !stat_o.m_zero) |=> (r_q < m_q))
    else $error("running result not reduced");

  a_b_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_b && !stat_o.m_zero) |=> (b_q < m_q))
    else $error("square not reduced");
`endif

endmodule

[rtl/core/modexp_ctrl.sv]
module modexp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  modexp_pkg::dp_stat_t stat_i,
  output modexp_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_RSTEP  = 4'd2;
  localparam logic [3:0] ST_RWR    = 4'd3;
  localparam logic [3:0] ST_BIT    = 4'd4;
  localparam logic [3:0] ST_MSTEP  = 4'd5;
  localparam logic [3:0] ST_MWR    = 4'd6;
  localparam logic [3:0] ST_SSTEP  = 4'd7;
  localparam logic [3:0] ST_SWR    = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = ovalid_q;
  assign out_free = !ovalid_q || m_tready;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !m_tready;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.m_zero) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.sel   = modexp_pkg::SEL_REDUCE;
          state_d     = ST_RSTEP;
        end
      end
      ST_RSTEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = ST_RWR;
        end
      end
      ST_RWR: begin
        cmd_o.wr_b = 1'b1;
        state_d    = ST_BIT;
      end
      ST_BIT: begin
        cmd_o.start = 1'b1;
        if (stat_i.e_lsb) begin
          cmd_o.sel = modexp_pkg::SEL_MUL_R;
          state_d   = ST_MSTEP;
        end else begin
          cmd_o.sel = modexp_pkg::SEL_SQUARE;
          state_d   = ST_SSTEP;
        end
      end
      ST_MSTEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = ST_MWR;
        end
      end
      ST_MWR: begin
        cmd_o.wr_r  = 1'b1;
        cmd_o.start = 1'b1;
        cmd_o.sel   = modexp_pkg::SEL_SQUARE;
        state_d     = ST_SSTEP;
      end
      ST_SSTEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = ST_SWR;
        end
      end
      ST_SWR: begin
        cmd_o.wr_b     = 1'b1;
        cmd_o.next_bit = 1'b1;
        state_d        = stat_i.bits_done ? ST_FIN : ST_BIT;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == ST_IDLE))
    else $error("load outside idle");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ovalid_q || m_tready))
    else $error("result overwritten before taken");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule
